>>> src/owtp_pkg.sv
// Shared types and constants for the 1-Wire temperature poller.
// Used by owtp_regs, owtp_core and one_wire_temperature_poller.
`default_nettype none

package owtp_pkg;

    // APB register file geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int CFG_W   = 20;   // widest timing register

    // 1-Wire ROM/function commands
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT_T  = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    typedef enum logic [2:0] {
        REG_POLL_INTERVAL = 3'd0,
        REG_CONV_WAIT     = 3'd1,
        REG_RESET_LOW     = 3'd2,
        REG_PRESENCE_DLY  = 3'd3,
        REG_RESET_TAIL    = 3'd4,
        REG_WRITE_ONE_LOW = 3'd5,
        REG_READ_LOW      = 3'd6,
        REG_SLOT_TIME     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_WAIT_CONVERT = 2'd0,
        PH_CONVERT      = 2'd1,
        PH_WAIT_READ    = 2'd2,
        PH_READ         = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_RESET_LOW = 3'd0,
        ST_PRESENCE  = 3'd1,
        ST_TAIL      = 3'd2,
        ST_SLOT_LOW  = 3'd3,
        ST_SLOT_HIGH = 3'd4
    } t_step;

    typedef struct packed {
        logic [19:0] poll_interval_us;
        logic [19:0] conversion_wait_us;
        logic [8:0]  reset_low_us;
        logic [7:0]  presence_delay_us;
        logic [8:0]  reset_tail_us;
        logic [3:0]  write_one_low_us;
        logic [3:0]  read_low_us;
        logic [6:0]  slot_time_us;
    } t_cfg;

    typedef struct packed {
        logic               drive_low;
        logic               temp_valid;
        logic signed [15:0] temperature;
        logic               presence_fail;
        logic               busy_res;
    } t_result;

endpackage

`default_nettype wire

>>> src/owtp_regs.sv
// APB configuration registers of the 1-Wire temperature poller.
// Depends on owtp_pkg for the register map and the t_cfg bundle.
`default_nettype none

module owtp_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owtp_pkg::PADDR_W-1:0] paddr,
    input  logic [owtp_pkg::PDATA_W-1:0] pwdata,
    output logic [owtp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output owtp_pkg::t_cfg               o_cfg
);
    import owtp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_POLL_INTERVAL: n_cfg.poll_interval_us   = pwdata[19:0];
                REG_CONV_WAIT:     n_cfg.conversion_wait_us = pwdata[19:0];
                REG_RESET_LOW:     n_cfg.reset_low_us       = pwdata[8:0];
                REG_PRESENCE_DLY:  n_cfg.presence_delay_us  = pwdata[7:0];
                REG_RESET_TAIL:    n_cfg.reset_tail_us      = pwdata[8:0];
                REG_WRITE_ONE_LOW: n_cfg.write_one_low_us   = pwdata[3:0];
                REG_READ_LOW:      n_cfg.read_low_us        = pwdata[3:0];
                REG_SLOT_TIME:     n_cfg.slot_time_us       = pwdata[6:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_POLL_INTERVAL: prdata = PDATA_W'(r_cfg.poll_interval_us);
            REG_CONV_WAIT:     prdata = PDATA_W'(r_cfg.conversion_wait_us);
            REG_RESET_LOW:     prdata = PDATA_W'(r_cfg.reset_low_us);
            REG_PRESENCE_DLY:  prdata = PDATA_W'(r_cfg.presence_delay_us);
            REG_RESET_TAIL:    prdata = PDATA_W'(r_cfg.reset_tail_us);
            REG_WRITE_ONE_LOW: prdata = PDATA_W'(r_cfg.write_one_low_us);
            REG_READ_LOW:      prdata = PDATA_W'(r_cfg.read_low_us);
            REG_SLOT_TIME:     prdata = PDATA_W'(r_cfg.slot_time_us);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_us   <= 20'd1000000;
            r_cfg.conversion_wait_us <= 20'd800000;
            r_cfg.reset_low_us       <= 9'd480;
            r_cfg.presence_delay_us  <= 8'd80;
            r_cfg.reset_tail_us      <= 9'd400;
            r_cfg.write_one_low_us   <= 4'd1;
            r_cfg.read_low_us        <= 4'd2;
            r_cfg.slot_time_us       <= 7'd60;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/owtp_core.sv
// Bus sequencer of the 1-Wire temperature poller: phase/step state, slot timer,
// elapsed counter and scratchpad shifter. Depends on owtp_pkg.
`default_nettype none

module owtp_core #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_us_tick,
    input  logic              i_bus_level,
    input  owtp_pkg::t_cfg    i_cfg,
    output owtp_pkg::t_result o_result
);
    import owtp_pkg::*;

    localparam int CMP_W = (INTERVAL_BITS > CFG_W) ? INTERVAL_BITS : CFG_W;

    t_phase                   r_phase,   n_phase;
    t_step                    r_step,    n_step;
    logic [8:0]               r_timer,   n_timer;
    logic [INTERVAL_BITS-1:0] r_elapsed, n_elapsed;
    logic [2:0]               r_bit,     n_bit;
    logic [1:0]               r_byte,    n_byte;
    logic [7:0]               r_shift,   n_shift;
    logic [7:0]               r_low,     n_low;
    logic [15:0]              r_temp,    n_temp;
    logic                     r_pres,    n_pres;

    logic       s_valid;
    logic       s_fail;
    logic       w_rd;
    logic       w_bit;
    logic [7:0] w_cmd;
    logic [8:0] w_dur;
    logic [9:0] w_tplus;
    logic       w_tmo;
    logic       w_busy;

    // slot decode
    assign w_rd  = (r_phase == PH_READ) && r_byte[1];
    assign w_cmd = (r_byte == 2'd0) ? CMD_SKIP_ROM
                 : ((r_phase == PH_CONVERT) ? CMD_CONVERT_T : CMD_READ_SCRPD);
    assign w_bit = w_cmd[r_bit];

    always_comb begin
        case (r_step)
            ST_RESET_LOW: w_dur = i_cfg.reset_low_us;
            ST_PRESENCE:  w_dur = 9'(i_cfg.presence_delay_us);
            ST_TAIL:      w_dur = i_cfg.reset_tail_us;
            ST_SLOT_LOW:  w_dur = w_rd  ? 9'(i_cfg.read_low_us)
                                : (w_bit ? 9'(i_cfg.write_one_low_us)
                                         : 9'(i_cfg.slot_time_us));
            ST_SLOT_HIGH: w_dur = (w_rd || w_bit) ? 9'(i_cfg.slot_time_us) : 9'd1;
            default:      w_dur = 9'd1;
        endcase
    end

    // step ends on the tick that brings the count to the duration
    assign w_tplus = {1'b0, r_timer} + 10'd1;
    assign w_tmo   = i_us_tick && (w_tplus >= {1'b0, w_dur});

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_timer   = r_timer;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_shift   = r_shift;
        n_low     = r_low;
        n_temp    = r_temp;
        n_pres    = r_pres;
        s_valid   = 1'b0;
        s_fail    = 1'b0;
        n_elapsed = (i_us_tick && (r_elapsed != '1)) ? r_elapsed + 1'b1 : r_elapsed;

        case (r_phase)
            PH_WAIT_CONVERT, PH_WAIT_READ: begin
                if ((r_phase == PH_WAIT_CONVERT)
                        ? (CMP_W'(n_elapsed) >= CMP_W'(i_cfg.poll_interval_us))
                        : (CMP_W'(n_elapsed) >= CMP_W'(i_cfg.conversion_wait_us))) begin
                    n_phase = (r_phase == PH_WAIT_CONVERT) ? PH_CONVERT : PH_READ;
                    n_step  = ST_RESET_LOW;
                    n_timer = '0;
                    n_bit   = '0;
                    n_byte  = '0;
                    n_shift = '0;
                    n_pres  = 1'b0;
                end
            end
            PH_CONVERT, PH_READ: begin
                if (i_us_tick) begin
                    n_timer = w_tmo ? 9'd0 : w_tplus[8:0];
                end
                case (r_step)
                    ST_RESET_LOW: begin
                        if (w_tmo) begin
                            n_step = ST_PRESENCE;
                        end
                    end
                    ST_PRESENCE: begin
                        if (w_tmo) begin
                            n_pres = !i_bus_level;
                            n_step = ST_TAIL;
                        end
                    end
                    ST_TAIL: begin
                        if (w_tmo) begin
                            if (r_pres) begin
                                n_step = ST_SLOT_LOW;
                            end else begin
                                s_fail  = 1'b1;
                                n_phase = PH_WAIT_CONVERT;
                                n_step  = ST_RESET_LOW;
                            end
                        end
                    end
                    ST_SLOT_LOW: begin
                        if (w_tmo) begin
                            n_step = ST_SLOT_HIGH;
                        end
                    end
                    ST_SLOT_HIGH: begin
                        // read bit sampled on the first tick after release
                        if (w_rd && i_us_tick && (r_timer == 9'd0)) begin
                            n_shift = {i_bus_level, r_shift[7:1]};
                        end
                        if (w_tmo) begin
                            n_step = ST_SLOT_LOW;
                            n_bit  = r_bit + 3'd1;
                            if (r_bit == 3'd7) begin
                                if ((r_phase == PH_CONVERT) && (r_byte == 2'd1)) begin
                                    n_elapsed = '0;
                                    n_phase   = PH_WAIT_READ;
                                    n_step    = ST_RESET_LOW;
                                end else if (w_rd && (r_byte == 2'd3)) begin
                                    n_temp  = {n_shift, r_low};
                                    s_valid = 1'b1;
                                    n_phase = PH_WAIT_CONVERT;
                                    n_step  = ST_RESET_LOW;
                                end else begin
                                    if (w_rd) begin
                                        n_low = n_shift;
                                    end
                                    n_shift = '0;
                                end
                                n_byte = r_byte + 2'd1;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT_CONVERT;
                        n_step  = ST_RESET_LOW;
                        n_timer = '0;
                    end
                endcase
            end
            default: begin
                n_phase = PH_WAIT_CONVERT;
            end
        endcase
    end

    // result word, taken from the post-update state
    always_comb begin
        w_busy                 = (n_phase == PH_CONVERT) || (n_phase == PH_READ);
        o_result.busy_res      = w_busy;
        o_result.drive_low     = w_busy && ((n_step == ST_RESET_LOW) || (n_step == ST_SLOT_LOW));
        o_result.temp_valid    = s_valid;
        o_result.presence_fail = s_fail;
        o_result.temperature   = signed'(n_temp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_CONVERT;
            r_step    <= ST_RESET_LOW;
            r_timer   <= '0;
            r_elapsed <= '0;
            r_bit     <= '0;
            r_byte    <= '0;
            r_shift   <= '0;
            r_low     <= '0;
            r_temp    <= '0;
            r_pres    <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_step    <= n_step;
            r_timer   <= n_timer;
            r_elapsed <= n_elapsed;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_low     <= n_low;
            r_temp    <= n_temp;
            r_pres    <= n_pres;
        end
    end

    // convert only ever sends two command bytes
    a_convert_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONVERT) |-> !r_byte[1])
        else $error("convert transaction past its command bytes");

    // a presence failure only ends a reset tail
    a_fail_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && s_fail) |-> (r_step == ST_TAIL && !r_pres))
        else $error("presence failure outside reset tail");

    // a new temperature only ends the last read byte
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && s_valid) |-> (r_phase == PH_READ && r_byte == 2'd3 && r_bit == 3'd7))
        else $error("temperature strobe outside last read byte");

endmodule

`default_nettype wire

>>> src/one_wire_temperature_poller.sv
// Top level of the 1-Wire temperature poller: input word register, sequencer,
// result register and APB registers. Depends on owtp_pkg, owtp_regs, owtp_core.
//
// Usage
//   Input channel: one word per system clock cycle while o_in_ready is high,
//   carrying i_us_tick (one microsecond elapsed) and i_bus_level (sampled
//   open-drain line). Every word advances the sequencer by exactly one step,
//   so the bus timing is counted in accepted words that carry a tick.
//   Output channel: one result word per input word, carrying o_drive_low (pull
//   the line low), o_temp_valid / o_presence_fail strobes, the held signed
//   temperature in 1/16 degC and o_busy_res.
//   The accepting edge loads the input register; the result register is
//   loaded when the sequencer advances on that word. Throughput: one word
//   per cycle while the output is not stalled; the sequencer step is a
//   single pass of logic between the two registers.
//   Stall: the input register keeps taking a word while a finished result
//   waits, and holds it until the result register frees; back-pressure then
//   reaches o_in_ready. No word is dropped or repeated.
//   Reset (i_rst_n low, synchronous): valid flags, sequencer and APB registers
//   return to defaults, the sequencer waits for the poll interval; r_out is not reset.
//   APB writes take effect at once; write only while the block is idle.
`default_nettype none

module one_wire_temperature_poller #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [owtp_pkg::PADDR_W-1:0] paddr,
    input  logic [owtp_pkg::PDATA_W-1:0] pwdata,
    output logic [owtp_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_us_tick,
    input  logic                         i_bus_level,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_drive_low,
    output logic                         o_temp_valid,
    output logic signed [15:0]           o_temperature,
    output logic                         o_presence_fail,
    output logic                         o_busy_res
);
    import owtp_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    r_in_valid;
    logic    r_us_tick;
    logic    r_bus_level;
    logic    w_advance;
    logic    w_in_take;

    owtp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // step the sequencer when a word is held and the result slot frees
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_us_tick   <= i_us_tick;
            r_bus_level <= i_bus_level;
        end
    end

    owtp_core #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_us_tick   (r_us_tick),
        .i_bus_level (r_bus_level),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_low     = r_out.drive_low;
    assign o_temp_valid    = r_out.temp_valid;
    assign o_temperature   = r_out.temperature;
    assign o_presence_fail = r_out.presence_fail;
    assign o_busy_res      = r_out.busy_res;

    // the line is only pulled low inside a transaction
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_drive_low || o_busy_res))
        else $error("bus driven low outside a transaction");

    // a held word stays until the sequencer consumes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_us_tick)
                                        && $stable(r_bus_level)))
        else $error("held input word lost");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_advance)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
